@@ design/tlsf_size_class_bitmap_search_defines.svh @@
// assertion macros for the size class bitmap search block
// used by the checker module, no other dependencies
`ifndef TLSF_SIZE_CLASS_BITMAP_SEARCH_DEFINES_SVH
`define TLSF_SIZE_CLASS_BITMAP_SEARCH_DEFINES_SVH

// same-cycle implication
`define TSB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsb assertion failed");

// next-cycle implication
`define TSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsb assertion failed");

`endif

@@ design/tsb_pkg.sv @@
// shared types and constants of the size class bitmap search block
// no dependencies
`default_nettype none

package tsb_pkg;

   localparam int SIZE_BITS    = 48;
   localparam int FL_OUT_BITS  = 5;
   localparam int SL_BITS      = 3;
   localparam int SL_COUNT     = 8;
   localparam int HEADER_BYTES = 32;
   localparam int MIN_BLOCK    = 64;
   localparam int MIN_SHIFT    = 6;
   localparam logic [SIZE_BITS-1:0] SIZE_SAT = 48'hFFFF_FFFF_FFF8;

   typedef enum logic [1:0] {
      CMD_SEARCH = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } tsb_command_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_FIT    = 3'd1,
      STATUS_ZERO      = 3'd2,
      STATUS_UNDERFLOW = 3'd3,
      STATUS_OVERFLOW  = 3'd4
   } tsb_status_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_UPDATE,
      ST_SEARCH_A,
      ST_SEARCH_B
   } tsb_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request item
      logic map_en;     // register class, start count read
      logic search_en;  // register find-first-set results
      logic commit;     // write result, update counts and bitmaps
   } tsb_ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic is_search;
      logic slot_free;
   } tsb_status_type;

endpackage

`default_nettype wire

@@ design/tsb_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module tsb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/tsb_ctrl.sv @@
// sequencing state machine of the size class bitmap search block
// depends on tsb_pkg
`default_nettype none

module tsb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [1:0]              req_command,
   output logic                         req_stall,
   input  wire tsb_pkg::tsb_status_type sts,
   output tsb_pkg::tsb_ctrl_type        ctl
);

   tsb_pkg::tsb_state_type state_ff, state_in;
   logic                   take_item;

   assign take_item = (state_ff == tsb_pkg::ST_IDLE) && req_valid &&
                      (req_command != tsb_pkg::CMD_NONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsb_pkg::ST_IDLE: begin
            if (take_item) begin
               state_in = tsb_pkg::ST_MAP;
            end
         end
         tsb_pkg::ST_MAP: begin
            state_in = sts.is_search ? tsb_pkg::ST_SEARCH_A : tsb_pkg::ST_UPDATE;
         end
         tsb_pkg::ST_SEARCH_A: begin
            state_in = tsb_pkg::ST_SEARCH_B;
         end
         tsb_pkg::ST_UPDATE, tsb_pkg::ST_SEARCH_B: begin
            if (sts.slot_free) begin
               state_in = tsb_pkg::ST_IDLE;
            end
         end
         default: state_in = tsb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tsb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = take_item;
         end
         tsb_pkg::ST_MAP:      ctl.map_en    = 1'b1;
         tsb_pkg::ST_SEARCH_A: ctl.search_en = 1'b1;
         tsb_pkg::ST_UPDATE, tsb_pkg::ST_SEARCH_B: begin
            ctl.commit = sts.slot_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ design/tsb_dp.sv @@
// datapath: size adjust, class mapping, bitmaps, search and count update
// depends on tsb_pkg and tsb_ram
`default_nettype none

module tsb_dp #(
   parameter int FIRST_LEVELS = 32,
   parameter int COUNT_BITS   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tsb_pkg::tsb_ctrl_type              ctl,
   output tsb_pkg::tsb_status_type                 sts,
   input  wire logic [1:0]                         req_command,
   input  wire logic [tsb_pkg::SIZE_BITS-1:0]      req_size_bytes,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [tsb_pkg::FL_OUT_BITS-1:0]    rsp_first_level,
   output logic      [tsb_pkg::SL_BITS-1:0]        rsp_second_level,
   output logic      [tsb_pkg::SIZE_BITS-1:0]      rsp_adjusted_size,
   output logic      [2:0]                         rsp_status
);

   localparam int FL_BITS   = $clog2(FIRST_LEVELS);
   localparam int LAST_FL   = FIRST_LEVELS - 1;
   localparam int ADDR_BITS = FL_BITS + tsb_pkg::SL_BITS;
   localparam int DEPTH     = FIRST_LEVELS * tsb_pkg::SL_COUNT;
   localparam int SB        = tsb_pkg::SIZE_BITS;
   localparam int SLB       = tsb_pkg::SL_BITS;

   function automatic logic [SLB-1:0] low_sl(input logic [tsb_pkg::SL_COUNT-1:0] v);
      logic [SLB-1:0] idx;
      idx = '0;
      for (int i = tsb_pkg::SL_COUNT - 1; i >= 0; i--) begin
         if (v[i]) idx = SLB'(i);
      end
      return idx;
   endfunction

   function automatic logic [FL_BITS-1:0] low_fl(input logic [FIRST_LEVELS-1:0] v);
      logic [FL_BITS-1:0] idx;
      idx = '0;
      for (int i = FIRST_LEVELS - 1; i >= 0; i--) begin
         if (v[i]) idx = FL_BITS'(i);
      end
      return idx;
   endfunction

   // item registers
   tsb_pkg::tsb_command_type cmd_ff, cmd_in;
   logic                     zero_ff, zero_in;
   logic [SB-1:0]            size_ff, size_in;
   logic [FL_BITS-1:0]       fl_ff, fl_in;
   logic [SLB-1:0]           sl_ff, sl_in;

   // search registers
   logic [FL_BITS-1:0]       f1_ff, f1_in, f2_ff, f2_in;
   logic [SLB-1:0]           s2_ff, s2_in;
   logic                     none1_ff, none1_in, none2_ff, none2_in, nones2_ff, nones2_in;

   // occupancy bitmaps
   logic [FIRST_LEVELS-1:0]          fbm_ff, fbm_in;
   logic [tsb_pkg::SL_COUNT-1:0]     slbm_ff [FIRST_LEVELS];
   logic [tsb_pkg::SL_COUNT-1:0]     slbm_in [FIRST_LEVELS];

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FL_BITS-1:0]            rfl_ff, rfl_in;
   logic [SLB-1:0]                rsl_ff, rsl_in;
   logic [SB-1:0]                 radj_ff, radj_in;
   tsb_pkg::tsb_status_code_type  rst_ff, rst_in;

   // size adjust
   logic [SB:0]   sum;
   logic [SB-1:0] adj;

   // class mapping
   logic [5:0]         top_idx;
   logic [5:0]         fidx;
   logic [5:0]         sh_amt;
   logic               below, big, above_raw;
   logic [SB-1:0]      shifted, low_mask;
   logic [FL_BITS-1:0] map_fl, rnd_fl;
   logic [SLB-1:0]     map_sl, rnd_sl;
   logic               map_above;

   // search
   logic [FIRST_LEVELS-1:0]      mask_ge, mask_gt;
   logic [tsb_pkg::SL_COUNT-1:0] srow;
   logic [FL_BITS-1:0]           target_fl;
   logic [SLB-1:0]               target_sl;
   logic [FL_BITS-1:0]           sfl;
   logic [SLB-1:0]               ssl;
   tsb_pkg::tsb_status_code_type sstat;

   // count update
   logic [COUNT_BITS-1:0] rd_data, cnt, new_cnt;
   logic                  hit, is_ins, upd_err, wr_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [tsb_pkg::SL_COUNT-1:0] row_clr;

   // header, align to 8, saturate, minimum block
   always_comb begin
      sum = {1'b0, req_size_bytes} + (SB + 1)'(tsb_pkg::HEADER_BYTES + 7);
      sum[2:0] = 3'b000;
      if (sum[SB]) begin
         adj = tsb_pkg::SIZE_SAT;
      end else if (sum[SB-1:0] < SB'(tsb_pkg::MIN_BLOCK)) begin
         adj = SB'(tsb_pkg::MIN_BLOCK);
      end else begin
         adj = sum[SB-1:0];
      end
   end

   always_comb begin
      cmd_in  = cmd_ff;
      zero_in = zero_ff;
      size_in = size_ff;
      if (ctl.load) begin
         cmd_in  = tsb_pkg::tsb_command_type'(req_command);
         zero_in = (req_size_bytes == '0);
         size_in = (cmd_in == tsb_pkg::CMD_SEARCH) ? adj : req_size_bytes;
      end
   end

   // leading one and class fields
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < SB; i++) begin
         if (size_ff[i]) top_idx = 6'(i);
      end
      below     = ~|size_ff[SB-1:tsb_pkg::MIN_SHIFT];
      fidx      = top_idx - 6'(tsb_pkg::MIN_SHIFT);
      big       = fidx >= 6'(LAST_FL);
      sh_amt    = top_idx - 6'(SLB);
      shifted   = size_ff >> sh_amt;
      low_mask  = (SB'(1) << sh_amt) - SB'(1);
      above_raw = |(size_ff & low_mask);
      if (below) begin
         map_fl = '0;
         map_sl = '0;
      end else if (big) begin
         map_fl = FL_BITS'(LAST_FL);
         map_sl = '0;
      end else begin
         map_fl = fidx[FL_BITS-1:0];
         map_sl = shifted[SLB-1:0];
      end
      map_above = !below && !big && above_raw;
      rnd_fl = map_fl;
      rnd_sl = map_sl;
      // search rounds up past a size above its class minimum
      if (cmd_ff == tsb_pkg::CMD_SEARCH && size_ff > SB'(tsb_pkg::MIN_BLOCK) && map_above) begin
         if (map_sl == SLB'(tsb_pkg::SL_COUNT - 1)) begin
            rnd_fl = map_fl + FL_BITS'(1);
            rnd_sl = '0;
         end else begin
            rnd_sl = map_sl + SLB'(1);
         end
      end
   end

   assign fl_in   = ctl.map_en ? rnd_fl : fl_ff;
   assign sl_in   = ctl.map_en ? rnd_sl : sl_ff;
   assign rd_addr = {map_fl, map_sl};

   // first search step: find-first-set at and above the class
   always_comb begin
      for (int i = 0; i < FIRST_LEVELS; i++) begin
         mask_ge[i] = FL_BITS'(i) >= fl_ff;
         mask_gt[i] = FL_BITS'(i) > fl_ff;
      end
      srow      = slbm_ff[fl_ff] & (tsb_pkg::SL_COUNT'('1) << sl_ff);
      f1_in     = f1_ff;
      f2_in     = f2_ff;
      s2_in     = s2_ff;
      none1_in  = none1_ff;
      none2_in  = none2_ff;
      nones2_in = nones2_ff;
      if (ctl.search_en) begin
         f1_in     = low_fl(fbm_ff & mask_ge);
         f2_in     = low_fl(fbm_ff & mask_gt);
         s2_in     = low_sl(srow);
         none1_in  = ~|(fbm_ff & mask_ge);
         none2_in  = ~|(fbm_ff & mask_gt);
         nones2_in = ~|srow;
      end
   end

   // second search step: choose class
   always_comb begin
      target_fl = (f1_ff == fl_ff) ? f2_ff : f1_ff;
      target_sl = low_sl(slbm_ff[target_fl]);
      sfl   = fl_ff;
      ssl   = sl_ff;
      sstat = tsb_pkg::STATUS_OK;
      if (zero_ff) begin
         sfl   = '0;
         ssl   = '0;
         sstat = tsb_pkg::STATUS_ZERO;
      end else if (fl_ff == FL_BITS'(LAST_FL)) begin
         // top class answers only for itself
         if (!slbm_ff[LAST_FL][0]) sstat = tsb_pkg::STATUS_NO_FIT;
      end else if (none1_ff) begin
         sstat = tsb_pkg::STATUS_NO_FIT;
      end else if (f1_ff == fl_ff && !nones2_ff) begin
         ssl = s2_ff;
      end else if (f1_ff == fl_ff && none2_ff) begin
         sstat = tsb_pkg::STATUS_NO_FIT;
      end else begin
         sfl = target_fl;
         ssl = target_sl;
      end
   end

   // count read-modify-write
   tsb_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({fl_ff, sl_ff}),
      .wr_data (new_cnt),
      .rd_en   (ctl.map_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      hit     = slbm_ff[fl_ff][sl_ff];
      cnt     = hit ? rd_data : '0;   // empty class reads as zero
      is_ins  = (cmd_ff == tsb_pkg::CMD_INSERT);
      upd_err = is_ins ? (&cnt) : !hit;
      new_cnt = is_ins ? cnt + COUNT_BITS'(1) : cnt - COUNT_BITS'(1);
      wr_en   = ctl.commit && !sts.is_search && !upd_err;
      row_clr = slbm_ff[fl_ff];
      row_clr[sl_ff] = 1'b0;
   end

   always_comb begin
      fbm_in = fbm_ff;
      for (int i = 0; i < FIRST_LEVELS; i++) begin
         slbm_in[i] = slbm_ff[i];
      end
      if (wr_en) begin
         if (is_ins) begin
            fbm_in[fl_ff]         = 1'b1;
            slbm_in[fl_ff][sl_ff] = 1'b1;
         end else if (new_cnt == '0) begin
            slbm_in[fl_ff][sl_ff] = 1'b0;
            if (row_clr == '0) fbm_in[fl_ff] = 1'b0;
         end
      end
   end

   // result register
   assign sts.is_search = (cmd_ff == tsb_pkg::CMD_SEARCH);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rfl_in  = rfl_ff;
      rsl_in  = rsl_ff;
      radj_in = radj_ff;
      rst_in  = rst_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
         if (sts.is_search) begin
            rfl_in  = sfl;
            rsl_in  = ssl;
            radj_in = zero_ff ? '0 : size_ff;
            rst_in  = sstat;
         end else begin
            rfl_in  = fl_ff;
            rsl_in  = sl_ff;
            radj_in = size_ff;
            if (!upd_err)    rst_in = tsb_pkg::STATUS_OK;
            else if (is_ins) rst_in = tsb_pkg::STATUS_OVERFLOW;
            else             rst_in = tsb_pkg::STATUS_UNDERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fbm_ff       <= '0;
         for (int i = 0; i < FIRST_LEVELS; i++) begin
            slbm_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fbm_ff       <= fbm_in;
         for (int i = 0; i < FIRST_LEVELS; i++) begin
            slbm_ff[i] <= slbm_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      zero_ff   <= zero_in;
      size_ff   <= size_in;
      fl_ff     <= fl_in;
      sl_ff     <= sl_in;
      f1_ff     <= f1_in;
      f2_ff     <= f2_in;
      s2_ff     <= s2_in;
      none1_ff  <= none1_in;
      none2_ff  <= none2_in;
      nones2_ff <= nones2_in;
      rfl_ff    <= rfl_in;
      rsl_ff    <= rsl_in;
      radj_ff   <= radj_in;
      rst_ff    <= rst_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_level   = tsb_pkg::FL_OUT_BITS'(rfl_ff);
   assign rsp_second_level  = rsl_ff;
   assign rsp_adjusted_size = radj_ff;
   assign rsp_status        = rst_ff;

endmodule

`default_nettype wire

@@ design/tlsf_size_class_bitmap_search.sv @@
// top level of the two-level segregated-fit size class index
// depends on tsb_pkg, tsb_ctrl, tsb_dp
//
// Size class index for a two-level segregated-fit heap. Holds a free-block
// count per class (FIRST_LEVELS x 8 classes, COUNT_BITS each) in a ram, plus
// first- and second-level occupancy bitmaps in flops; all are empty after
// reset with no clearing pass, since a class whose bitmap bit is clear reads
// its count as zero. One item is worked on at a time: insert and remove go
// through accept, class map with count read, count write and bitmap update;
// search through accept with size adjust, class map, find-first-set over
// the masked bitmaps and class select. The count ram's read-modify-write and
// the two-step bitmap search set these steps. The result sits in an output
// register, so a new item is accepted while the previous result waits to be
// taken. Command 3 is accepted and dropped.
`default_nettype none

module tlsf_size_class_bitmap_search #(
   parameter int FIRST_LEVELS = 32,
   parameter int COUNT_BITS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [47:0] req_size_bytes,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [4:0]  rsp_first_level,
   output logic      [2:0]  rsp_second_level,
   output logic      [47:0] rsp_adjusted_size,
   output logic      [2:0]  rsp_status
);

   tsb_pkg::tsb_ctrl_type   ctl;
   tsb_pkg::tsb_status_type sts;

   // sequencer: idle, map, then update or two search steps
   tsb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .sts         (sts),
      .ctl         (ctl)
   );

   // size adjust, class map, count ram, bitmaps and result register
   tsb_dp #(
      .FIRST_LEVELS (FIRST_LEVELS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_size_bytes    (req_size_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_level   (rsp_first_level),
      .rsp_second_level  (rsp_second_level),
      .rsp_adjusted_size (rsp_adjusted_size),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

@@ design/tsb_checker.sv @@
// port-level checker of the size class bitmap search block, bound to the top
// depends on tsb_pkg and tlsf_size_class_bitmap_search_defines.svh
`default_nettype none
`include "tlsf_size_class_bitmap_search_defines.svh"

module tsb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_command,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [4:0]  rsp_first_level,
   input wire logic [2:0]  rsp_second_level,
   input wire logic [47:0] rsp_adjusted_size,
   input wire logic [2:0]  rsp_status
);

   // a real command keeps the block busy next cycle
   `TSB_ASSERT_NEXT(a_busy_after_item, clock, reset, req_valid && !req_stall && req_command != tsb_pkg::CMD_NONE, req_stall)

   // a fresh result only follows a cycle of work
   `TSB_ASSERT_SAME(a_result_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // zero request reports an all-zero class and size
   `TSB_ASSERT_SAME(a_zero_request, clock, reset, rsp_valid && rsp_status == tsb_pkg::STATUS_ZERO, rsp_first_level == 5'd0 && rsp_second_level == 3'd0 && rsp_adjusted_size == 48'd0)

   // held result keeps its size and status
   `TSB_ASSERT_NEXT(a_result_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_adjusted_size) && $stable(rsp_status))

endmodule

bind tlsf_size_class_bitmap_search tsb_checker u_tsb_checker (.*);

`default_nettype wire
